/* src/crlm_pkg.sv */
// shared types and constants of the column range list matcher
package crlm_pkg;

   // spec characters
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // widths of the fixed payload fields
   localparam int COLUMN_W    = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   // character classes found by the front end
   localparam logic [1:0] CLS_OTHER = 2'd0;
   localparam logic [1:0] CLS_DIGIT = 2'd1;
   localparam logic [1:0] CLS_DASH  = 2'd2;
   localparam logic [1:0] CLS_COMMA = 2'd3;

   // entry kinds held in the range table
   localparam logic [1:0] KIND_SINGLE   = 2'd1;
   localparam logic [1:0] KIND_STARTEND = 2'd2;
   localparam logic [1:0] KIND_GE       = 2'd3;

   // sticky status codes
   localparam logic [STATUS_W-1:0] STAT_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DOUBLE_DASH    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DASH_NO_START  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ZERO_START     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_END        = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_ZERO_SINGLE    = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL     = 3'd6;

   // classified item passed from front end to back end
   typedef struct packed {
      logic                is_query;
      logic [1:0]          cls;
      logic [3:0]          digit;
      logic                spec_last;
      logic [COLUMN_W-1:0] column;
   } item_type;

endpackage

/* src/column_range_list_matcher_unit.sv */
// top level of the column range list matcher
//
// Spec characters (mode 0) build a list of column ranges such as 1-3,5,7-
// in a table of MAX_RANGES entries; queries (mode 1) report whether a
// column falls in any stored range. Each transfer in gives exactly one
// response transfer carrying the match flag, the sticky status code and the
// number of stored ranges. The back end parses a spec character and answers
// it from its idle state. A query walks the table from its first entry, as
// the table memory is read one entry per cycle through its single read port,
// and stops at the first hit or the last entry; a query with an error status
// or an empty table is answered without a walk. A two-entry queue behind the
// request port and a response register let both sides stall on their own.
module column_range_list_matcher_unit
   import crlm_pkg::*;
#(
   parameter int MAX_RANGES = 16,
   parameter int NUM_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [7:0]             req_char_code,
   input  logic                   req_spec_last,
   input  logic [COLUMN_W-1:0]    req_column,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_matched,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_range_count
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   // request side: classify and queue
   crlm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .req_spec_last (req_spec_last),
      .req_column    (req_column),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   // execution side: parse, table walk and response
   crlm_back #(
      .MAX_RANGES (MAX_RANGES),
      .NUM_BITS   (NUM_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_matched     (rsp_matched),
      .rsp_status      (rsp_status),
      .rsp_range_count (rsp_range_count)
   );

endmodule

/* src/crlm_ram.sv */
// generic single write port, single read port ram with registered read
module crlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/crlm_front.sv */
// front end: accepts request transfers, classifies them and queues them
module crlm_front
   import crlm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [7:0]          req_char_code,
   input  logic                req_spec_last,
   input  logic [COLUMN_W-1:0] req_column,
   output logic                item_valid,
   output item_type            item,
   input  logic                item_pop
);

   item_type   q_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;
   item_type   cls_item;

   // classify the incoming character
   always_comb begin
      cls_item.is_query  = req_mode;
      cls_item.spec_last = req_spec_last;
      cls_item.column    = req_column;
      cls_item.digit     = 4'(req_char_code - CHAR_ZERO);
      if (req_char_code >= CHAR_ZERO && req_char_code <= CHAR_NINE) begin
         cls_item.cls = CLS_DIGIT;
      end else if (req_char_code == CHAR_DASH) begin
         cls_item.cls = CLS_DASH;
      end else if (req_char_code == CHAR_COMMA) begin
         cls_item.cls = CLS_COMMA;
      end else begin
         cls_item.cls = CLS_OTHER;
      end
   end

   // two-entry queue toward the back end
   assign req_stall  = (fill_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && (fill_ff != 2'd0);
   assign item_valid = (fill_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

/* src/crlm_back.sv */
// back end: spec parser, range table walk and response register
module crlm_back
   import crlm_pkg::*;
#(
   parameter int MAX_RANGES = 16,
   parameter int NUM_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  item_type               item,
   output logic                   item_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_matched,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_range_count
);

   localparam int ADDR_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W   = $clog2(MAX_RANGES + 1);
   localparam int WIDE_W  = NUM_BITS + 4;
   localparam int ENTRY_W = 2 * NUM_BITS + 2;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                   state_ff, state_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [COLUMN_W-1:0]    col_ff, col_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [STATUS_W-1:0]    err_ff, err_in;
   logic [NUM_BITS-1:0]    acc_ff, acc_in;
   logic                   dseen_ff, dseen_in;
   logic                   dash_ff, dash_in;
   logic [NUM_BITS-1:0]    pstart_ff, pstart_in;
   logic                   ended_ff, ended_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]     rd_data;

   logic                   slot_free;
   logic [NUM_BITS-1:0]    ent_lo;
   logic [NUM_BITS-1:0]    ent_hi;
   logic [1:0]             ent_kind;
   logic                   hit;
   logic                   walk_last;

   // range table
   crlm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare the column with the entry read last cycle
   assign ent_lo    = rd_data[NUM_BITS-1:0];
   assign ent_hi    = rd_data[2*NUM_BITS-1:NUM_BITS];
   assign ent_kind  = rd_data[ENTRY_W-1:2*NUM_BITS];
   assign walk_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   always_comb begin
      unique case (ent_kind)
         KIND_SINGLE:   hit = (col_ff == COLUMN_W'(ent_lo));
         KIND_STARTEND: hit = (col_ff >= COLUMN_W'(ent_lo)) && (col_ff <= COLUMN_W'(ent_hi));
         KIND_GE:       hit = (col_ff >= COLUMN_W'(ent_lo));
         default:       hit = 1'b0;
      endcase
   end

   // response slot is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // parse, append and walk control
   always_comb begin
      logic [WIDE_W-1:0]   wide;
      logic                close_now;
      logic                append;
      logic [NUM_BITS-1:0] ap_lo;
      logic [NUM_BITS-1:0] ap_hi;
      logic [1:0]          ap_kind;

      wide      = '0;
      close_now = 1'b0;
      append    = 1'b0;
      ap_lo     = '0;
      ap_hi     = '0;
      ap_kind   = KIND_SINGLE;

      state_in       = state_ff;
      idx_in         = idx_ff;
      col_in         = col_ff;
      cnt_in         = cnt_ff;
      err_in         = err_ff;
      acc_in         = acc_ff;
      dseen_in       = dseen_ff;
      dash_in        = dash_ff;
      pstart_in      = pstart_ff;
      ended_in       = ended_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      item_pop       = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cnt_ff[ADDR_W-1:0];
      wr_data        = '0;
      rd_addr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && slot_free) begin
               item_pop = 1'b1;
               if (item.is_query) begin
                  if (err_ff != STAT_OK || cnt_ff == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_matched_in = 1'b0;
                     rsp_status_in  = err_ff;
                     rsp_count_in   = COUNT_OUT_W'(cnt_ff);
                  end else begin
                     state_in = ST_WALK;
                     idx_in   = '0;
                     col_in   = item.column;
                     rd_addr  = '0;
                  end
               end else begin
                  // a new spec clears the table and parse state
                  if (ended_ff) begin
                     cnt_in    = '0;
                     err_in    = STAT_OK;
                     acc_in    = '0;
                     dseen_in  = 1'b0;
                     dash_in   = 1'b0;
                     pstart_in = '0;
                     ended_in  = 1'b0;
                  end
                  // character step
                  if (err_in == STAT_OK) begin
                     unique case (item.cls) inside
                        CLS_DIGIT: begin
                           wide = (WIDE_W'(acc_in) << 3) + (WIDE_W'(acc_in) << 1)
                                + WIDE_W'(item.digit);
                           if (wide[WIDE_W-1:NUM_BITS] != '0) begin
                              acc_in = '1;
                           end else begin
                              acc_in = wide[NUM_BITS-1:0];
                           end
                           dseen_in = 1'b1;
                        end
                        CLS_DASH: begin
                           if (dash_in) begin
                              err_in = STAT_DOUBLE_DASH;
                           end else begin
                              dash_in = 1'b1;
                              if (!dseen_in) begin
                                 err_in = STAT_DASH_NO_START;
                              end else if (acc_in == '0) begin
                                 err_in = STAT_ZERO_START;
                              end else begin
                                 pstart_in = acc_in;
                                 acc_in    = '0;
                                 dseen_in  = 1'b0;
                              end
                           end
                        end
                        CLS_COMMA, CLS_OTHER: begin
                        end
                        default: begin
                        end
                     endcase
                  end
                  // entry close on comma or end of spec
                  close_now = (err_in == STAT_OK)
                            && ((item.cls == CLS_COMMA) || item.spec_last);
                  if (close_now) begin
                     if (!dseen_in) begin
                        if (dash_in) begin
                           append  = 1'b1;
                           ap_lo   = pstart_in;
                           ap_hi   = pstart_in;
                           ap_kind = KIND_GE;
                        end
                     end else if (dash_in) begin
                        if (acc_in == '0 || pstart_in > acc_in) begin
                           err_in = STAT_BAD_END;
                        end else if (pstart_in == acc_in) begin
                           append  = 1'b1;
                           ap_lo   = pstart_in;
                           ap_hi   = pstart_in;
                           ap_kind = KIND_SINGLE;
                        end else begin
                           append  = 1'b1;
                           ap_lo   = pstart_in;
                           ap_hi   = acc_in;
                           ap_kind = KIND_STARTEND;
                        end
                     end else begin
                        if (acc_in == '0) begin
                           err_in = STAT_ZERO_SINGLE;
                        end else begin
                           append  = 1'b1;
                           ap_lo   = acc_in;
                           ap_hi   = acc_in;
                           ap_kind = KIND_SINGLE;
                        end
                     end
                     if (append) begin
                        if (cnt_in >= CNT_W'(MAX_RANGES)) begin
                           err_in = STAT_TABLE_FULL;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = cnt_in[ADDR_W-1:0];
                           wr_data = {ap_kind, ap_hi, ap_lo};
                           cnt_in  = cnt_in + CNT_W'(1);
                        end
                     end
                     acc_in    = '0;
                     dseen_in  = 1'b0;
                     dash_in   = 1'b0;
                     pstart_in = '0;
                  end
                  // end of spec
                  if (item.spec_last) begin
                     acc_in    = '0;
                     dseen_in  = 1'b0;
                     dash_in   = 1'b0;
                     pstart_in = '0;
                     ended_in  = 1'b1;
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b0;
                  rsp_status_in  = err_in;
                  rsp_count_in   = COUNT_OUT_W'(cnt_in);
               end
            end
         end
         ST_WALK: begin
            // one table entry per cycle until a hit or the last entry
            if (hit || walk_last) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = hit;
               rsp_status_in  = err_ff;
               rsp_count_in   = COUNT_OUT_W'(cnt_ff);
            end else begin
               idx_in  = idx_ff + ADDR_W'(1);
               rd_addr = idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         err_ff       <= STAT_OK;
         acc_ff       <= '0;
         dseen_ff     <= 1'b0;
         dash_ff      <= 1'b0;
         pstart_ff    <= '0;
         ended_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         acc_ff       <= acc_in;
         dseen_ff     <= dseen_in;
         dash_ff      <= dash_in;
         pstart_ff    <= pstart_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      col_ff         <= col_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_range_count = rsp_count_ff;

endmodule
